/* rtl/clns_pkg.sv */
`timescale 1ns / 1ps

package clns_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned IDX_W       = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_TWO_BASE   = 2'd0,
        CFG_FUNCTION_SET    = 2'd1,
        CFG_DISPLAY_CONTROL = 2'd2,
        CFG_ENTRY_MODE      = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_PUT_CHAR   = 3'd1,
        OP_GOTO       = 3'd2,
        OP_CLEAR_HOME = 3'd3,
        OP_SET_DDRAM  = 3'd4,
        OP_SET_CGRAM  = 3'd5,
        OP_DATA       = 3'd6
    } op_t;

    localparam logic [7:0] CHAR_BELL      = 8'd7;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_FORM_FEED = 8'd12;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM  = 8'h40;

    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    localparam logic [6:0] PAUSE_POWER_UP   = 7'd80;
    localparam logic [6:0] PAUSE_RS_SETUP   = 7'd2;
    localparam logic [4:0] PAUSE_INIT_STEP  = 5'd5;
    localparam logic [4:0] PAUSE_INIT_SWAP  = 5'd20;
    localparam logic [4:0] PAUSE_FORM_FEED  = 5'd2;

    localparam logic [IDX_W-1:0] LAST_IDX_INIT = 4'd11;
    localparam logic [IDX_W-1:0] LAST_IDX_BYTE = 4'd1;
    localparam logic [IDX_W-1:0] LAST_IDX_PAIR = 4'd3;
    localparam logic [IDX_W-1:0] INIT_PREFIX   = 4'd4;

    localparam logic [6:0] RST_LINE_TWO_BASE   = 7'd64;
    localparam logic [7:0] RST_FUNCTION_SET    = 8'd40;
    localparam logic [7:0] RST_DISPLAY_CONTROL = 8'd14;
    localparam logic [7:0] RST_ENTRY_MODE      = 8'd6;

    typedef enum logic [1:0] {
        JOB_INIT = 2'd0,
        JOB_BYTE = 2'd1,
        JOB_PAIR = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [6:0] line_two_base;
        logic [7:0] function_set_cmd;
        logic [7:0] display_control_cmd;
        logic [7:0] entry_mode_cmd;
    } cfg_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] data;
        logic [4:0] pause_after;
    } job_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [6:0] pause_before_ms;
        logic [4:0] pause_after_ms;
        logic       last;
    } nib_t;

    function automatic logic [7:0] goto_cmd(input logic [6:0] base, input logic [5:0] column);
        logic [6:0] addr;
        begin
            addr = base + {1'b0, column} + 7'h7F;
            goto_cmd = CMD_SET_DDRAM | {1'b0, addr};
        end
    endfunction

    function automatic logic [IDX_W-1:0] last_idx(input job_kind_t kind);
        begin
            case (kind)
                JOB_INIT: last_idx = LAST_IDX_INIT;
                JOB_PAIR: last_idx = LAST_IDX_PAIR;
                default:  last_idx = LAST_IDX_BYTE;
            endcase
        end
    endfunction

endpackage

/* rtl/clns_if.sv */
`timescale 1ns / 1ps

interface clns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] row;

    modport source (output valid, output op, output value, output column, output row,
                    input ready);
    modport sink   (input valid, input op, input value, input column, input row,
                    output ready);
endinterface

interface clns_nib_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] nibble;
    logic [6:0] pause_before_ms;
    logic [4:0] pause_after_ms;
    logic       last;

    modport source (output valid, output reg_select, output nibble, output pause_before_ms,
                    output pause_after_ms, output last, input ready);
    modport sink   (input valid, input reg_select, input nibble, input pause_before_ms,
                    input pause_after_ms, input last, output ready);
endinterface

/* rtl/clns_decode.sv */
`timescale 1ns / 1ps

module clns_decode
(
    input  logic [2:0]    op,
    input  logic [7:0]    value,
    input  logic [5:0]    column,
    input  logic [1:0]    row,
    input  logic [6:0]    line_two_base,
    output clns_pkg::job_t job,
    output logic          job_valid
);

    logic [6:0] row_base;

    assign row_base = (row == 2'd2) ? line_two_base : 7'd0;

    always_comb
    begin
        job_valid       = 1'b1;
        job.kind        = clns_pkg::JOB_BYTE;
        job.rs          = 1'b0;
        job.data        = value;
        job.pause_after = 5'd0;
        case (op)
            clns_pkg::OP_INIT:
            begin
                job.kind        = clns_pkg::JOB_INIT;
                job.pause_after = clns_pkg::PAUSE_INIT_STEP;
            end
            clns_pkg::OP_PUT_CHAR:
            begin
                case (value)
                    clns_pkg::CHAR_BELL:
                        job.data = clns_pkg::goto_cmd(7'd0, 6'd1);
                    clns_pkg::CHAR_FORM_FEED:
                    begin
                        job.data        = clns_pkg::CMD_CLEAR;
                        job.pause_after = clns_pkg::PAUSE_FORM_FEED;
                    end
                    clns_pkg::CHAR_NEWLINE:
                        job.data = clns_pkg::goto_cmd(line_two_base, 6'd1);
                    clns_pkg::CHAR_BACKSPACE:
                        job.data = clns_pkg::CMD_SHIFT_LEFT;
                    default:
                        job.rs = 1'b1;
                endcase
            end
            clns_pkg::OP_GOTO:
                job.data = clns_pkg::goto_cmd(row_base, column);
            clns_pkg::OP_CLEAR_HOME:
            begin
                job.kind = clns_pkg::JOB_PAIR;
                job.data = clns_pkg::CMD_CLEAR;
            end
            clns_pkg::OP_SET_DDRAM:
                job.data = clns_pkg::CMD_SET_DDRAM | {1'b0, value[6:0]};
            clns_pkg::OP_SET_CGRAM:
                job.data = clns_pkg::CMD_SET_CGRAM | {2'b00, value[5:0]};
            clns_pkg::OP_DATA:
                job.rs = 1'b1;
            default:
                job_valid = 1'b0;
        endcase
    end

endmodule

/* rtl/clns_nibble_gen.sv */
`timescale 1ns / 1ps

module clns_nibble_gen
(
    input  clns_pkg::job_t             job,
    input  logic [clns_pkg::IDX_W-1:0] idx,
    input  clns_pkg::cfg_t             cfg,
    output clns_pkg::nib_t             nib
);

    logic [clns_pkg::IDX_W-1:0] init_off;
    logic [7:0]                 cur_byte;
    logic                       high_half;

    assign init_off  = idx - clns_pkg::INIT_PREFIX;
    assign high_half = ~idx[0];

    // pick the byte that this nibble belongs to
    always_comb
    begin
        cur_byte = job.data;
        case (job.kind)
            clns_pkg::JOB_INIT:
            begin
                case (init_off[2:1])
                    2'd0:    cur_byte = cfg.function_set_cmd;
                    2'd1:    cur_byte = cfg.display_control_cmd;
                    2'd2:    cur_byte = cfg.entry_mode_cmd;
                    default: cur_byte = clns_pkg::CMD_CLEAR;
                endcase
            end
            clns_pkg::JOB_PAIR:
                cur_byte = idx[1] ? clns_pkg::CMD_HOME : clns_pkg::CMD_CLEAR;
            default:
                cur_byte = job.data;
        endcase
    end

    always_comb
    begin
        nib.reg_select      = job.rs;
        nib.nibble          = high_half ? cur_byte[7:4] : cur_byte[3:0];
        nib.pause_before_ms = high_half ? clns_pkg::PAUSE_RS_SETUP : 7'd0;
        nib.pause_after_ms  = high_half ? 5'd0 : job.pause_after;
        nib.last            = (idx == clns_pkg::last_idx(job.kind));
        // wake-up prefix of init: 3, 3, 3, 2 without select setup
        if (job.kind == clns_pkg::JOB_INIT && idx < clns_pkg::INIT_PREFIX)
        begin
            nib.reg_select      = 1'b0;
            nib.nibble          = (idx == 4'd3) ? clns_pkg::NIB_FOUR_BIT : clns_pkg::NIB_WAKE;
            nib.pause_before_ms = (idx == 4'd0) ? clns_pkg::PAUSE_POWER_UP : 7'd0;
            nib.pause_after_ms  = (idx == 4'd3) ? clns_pkg::PAUSE_INIT_SWAP
                                                : clns_pkg::PAUSE_INIT_STEP;
        end
    end

endmodule

/* rtl/char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps

// Character LCD nibble sequencer, 4-bit bus.
// req:  display requests (op, value, column, row), valid/ready.
// nib:  one transfer per nibble strobe (reg_select, nibble, pauses, last),
//       valid/ready; the downstream strobe timer applies the pauses.
// cfg:  write port for line-two base and the three init set-up bytes;
//       write only while no request is in flight.
// A request is held in a job register and walked one nibble per cycle,
// unless nib stalls, into an output register; the first nibble passes
// the job register, then the output register. A request yields 2 nibbles
// (single byte), 4 (clear and home) or 12 (init); the next request is
// taken in the cycle its predecessor's last nibble enters the output
// register, so an unstalled stream of valid requests runs back to back.
// An unused op code is taken and yields nothing.
// When nib is stalled the output register holds and the job register
// stops advancing; req.ready drops until the last nibble moves.
// Reset loads the register defaults (base 64, bytes 40, 14, 6) and
// empties the job and output registers.
module char_lcd_nibble_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,
    clns_req_if.sink                         req,
    clns_nib_if.source                       nib,
    input  logic                             cfg_we,
    input  logic [clns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    clns_pkg::cfg_t             cfg_reg;
    clns_pkg::job_t             job_reg;
    logic                       job_valid_reg;
    logic [clns_pkg::IDX_W-1:0] idx_reg;
    logic                       out_valid_reg;
    clns_pkg::nib_t             out_reg;

    clns_pkg::job_t             dec_job;
    logic                       dec_valid;
    clns_pkg::nib_t             gen_nib;
    logic                       out_adv;
    logic                       job_step;
    logic                       job_done;
    logic                       req_xfer;

    clns_decode u_decode
    (
        .op            (req.op),
        .value         (req.value),
        .column        (req.column),
        .row           (req.row),
        .line_two_base (cfg_reg.line_two_base),
        .job           (dec_job),
        .job_valid     (dec_valid)
    );

    clns_nibble_gen u_nibble_gen
    (
        .job (job_reg),
        .idx (idx_reg),
        .cfg (cfg_reg),
        .nib (gen_nib)
    );

    assign out_adv   = ~out_valid_reg | nib.ready;
    assign job_step  = job_valid_reg & out_adv;
    assign job_done  = job_step & gen_nib.last;
    assign req.ready = ~job_valid_reg | job_done;
    assign req_xfer  = req.valid & req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_two_base       <= clns_pkg::RST_LINE_TWO_BASE;
            cfg_reg.function_set_cmd    <= clns_pkg::RST_FUNCTION_SET;
            cfg_reg.display_control_cmd <= clns_pkg::RST_DISPLAY_CONTROL;
            cfg_reg.entry_mode_cmd      <= clns_pkg::RST_ENTRY_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clns_pkg::CFG_LINE_TWO_BASE:   cfg_reg.line_two_base       <= cfg_data[6:0];
                clns_pkg::CFG_FUNCTION_SET:    cfg_reg.function_set_cmd    <= cfg_data;
                clns_pkg::CFG_DISPLAY_CONTROL: cfg_reg.display_control_cmd <= cfg_data;
                clns_pkg::CFG_ENTRY_MODE:      cfg_reg.entry_mode_cmd      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_xfer)
            begin
                job_valid_reg <= dec_valid;
                idx_reg       <= '0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (job_step)
            begin
                idx_reg <= idx_reg + 4'd1;
            end

            if (out_adv)
            begin
                out_valid_reg <= job_valid_reg;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            job_reg <= dec_job;
        end
        if (job_step)
        begin
            out_reg <= gen_nib;
        end
    end

    assign nib.valid           = out_valid_reg;
    assign nib.reg_select      = out_reg.reg_select;
    assign nib.nibble          = out_reg.nibble;
    assign nib.pause_before_ms = out_reg.pause_before_ms;
    assign nib.pause_after_ms  = out_reg.pause_after_ms;
    assign nib.last            = out_reg.last;

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (idx_reg <= clns_pkg::last_idx(job_reg.kind)))
        else $error("nibble index beyond end of job");

    a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && job_valid_reg) |-> job_done)
        else $error("request taken while job still has nibbles");

    a_job_after_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> job_valid_reg)
        else $error("job dropped before its last nibble");

    a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (job_step && !gen_nib.last && !req_xfer) |=> (idx_reg == $past(idx_reg) + 4'd1))
        else $error("job index did not advance");
`endif

endmodule

/* verif/tb_char_lcd_nibble_sequencer.sv */
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;
    import clns_pkg::*;

    localparam logic [2:0] OP_UNUSED      = 3'd7;
    localparam int         SETTLE_CYCLES  = 24;
    localparam int         LONG_HOLD      = 150;
    localparam int         WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
    } lcd_req_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;

    clns_req_if req_if ();
    clns_nib_if nib_if ();

    char_lcd_nibble_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .nib       (nib_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfg_t     lcd_cfg;
    lcd_req_t req_backlog [$];
    nib_t     strobe_q [$];
    int       reqs_queued   = 0;
    int       reqs_accepted = 0;
    int       errors        = 0;
    int       idle_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Strobe predictor
    // ---------------------------------------------------------------
    function automatic void push_strobe(logic rs, logic [3:0] nib, logic [6:0] pause_pre,
                                        logic [4:0] after);
        nib_t s;
        s.reg_select      = rs;
        s.nibble          = nib;
        s.pause_before_ms = pause_pre;
        s.pause_after_ms  = after;
        s.last            = 1'b0;
        strobe_q.push_back(s);
    endfunction

    function automatic void push_byte(logic rs, logic [7:0] b, logic [4:0] after);
        push_strobe(rs, b[7:4], PAUSE_RS_SETUP, 5'd0);
        push_strobe(rs, b[3:0], 7'd0, after);
    endfunction

    // Display address for a one-based column; only row two uses the line base.
    function automatic logic [7:0] ddram_for(int column, int row);
        int base;
        int addr;
        base = (row == 2) ? int'(lcd_cfg.line_two_base) : 0;
        addr = (base + column - 1) & 32'h7F;
        return CMD_SET_DDRAM | 8'(addr);
    endfunction

    function automatic void predict_strobes(lcd_req_t r);
        int depth;
        depth = strobe_q.size();
        case (r.op)
            OP_INIT:
            begin
                push_strobe(1'b0, NIB_WAKE, PAUSE_POWER_UP, PAUSE_INIT_STEP);
                push_strobe(1'b0, NIB_WAKE, 7'd0, PAUSE_INIT_STEP);
                push_strobe(1'b0, NIB_WAKE, 7'd0, PAUSE_INIT_STEP);
                push_strobe(1'b0, NIB_FOUR_BIT, 7'd0, PAUSE_INIT_SWAP);
                push_byte(1'b0, lcd_cfg.function_set_cmd, PAUSE_INIT_STEP);
                push_byte(1'b0, lcd_cfg.display_control_cmd, PAUSE_INIT_STEP);
                push_byte(1'b0, lcd_cfg.entry_mode_cmd, PAUSE_INIT_STEP);
                push_byte(1'b0, CMD_CLEAR, PAUSE_INIT_STEP);
            end
            OP_PUT_CHAR:
            begin
                case (r.value)
                    CHAR_BELL:      push_byte(1'b0, ddram_for(1, 1), 5'd0);
                    CHAR_FORM_FEED: push_byte(1'b0, CMD_CLEAR, PAUSE_FORM_FEED);
                    CHAR_NEWLINE:   push_byte(1'b0, ddram_for(1, 2), 5'd0);
                    CHAR_BACKSPACE: push_byte(1'b0, CMD_SHIFT_LEFT, 5'd0);
                    default:        push_byte(1'b1, r.value, 5'd0);
                endcase
            end
            OP_GOTO:       push_byte(1'b0, ddram_for(int'(r.column), int'(r.row)), 5'd0);
            OP_CLEAR_HOME:
            begin
                push_byte(1'b0, CMD_CLEAR, 5'd0);
                push_byte(1'b0, CMD_HOME, 5'd0);
            end
            OP_SET_DDRAM:  push_byte(1'b0, CMD_SET_DDRAM | {1'b0, r.value[6:0]}, 5'd0);
            OP_SET_CGRAM:  push_byte(1'b0, CMD_SET_CGRAM | {2'b00, r.value[5:0]}, 5'd0);
            OP_DATA:       push_byte(1'b1, r.value, 5'd0);
            default:       ;
        endcase
        if (strobe_q.size() > depth)
            strobe_q[strobe_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------
    // Request driver: bursts with gaps, and now and then a full drain
    // ---------------------------------------------------------------
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  bursts_done = 0;
    bit  drain_hold  = 1'b0;

    always @(posedge clk)
    begin : req_driver
        lcd_req_t next;
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_if.ready)
        begin
            if (drain_hold && strobe_q.size() == 0)
                drain_hold = 1'b0;
            if (gap_left > 0 || drain_hold || req_backlog.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                req_if.valid <= 1'b0;
            end
            else
            begin
                next = req_backlog.pop_front();
                req_if.valid  <= 1'b1;
                req_if.op     <= next.op;
                req_if.value  <= next.value;
                req_if.column <= next.column;
                req_if.row    <= next.row;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    bursts_done++;
                    if (bursts_done == 4 || $urandom_range(0, 29) == 0)
                        drain_hold = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Strobe receiver: changing stall modes plus a few long hold-offs
    // ---------------------------------------------------------------
    int stall_mode  = 0;
    int mode_left   = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    bit toggle      = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            nib_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            nib_if.ready <= 1'b0;
        end
        else if (holds_done < 3 && reqs_accepted >= 60 + 100 * holds_done)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            nib_if.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left--;
            toggle = ~toggle;
            case (stall_mode)
                0:       nib_if.ready <= 1'b1;
                1:       nib_if.ready <= ($urandom_range(0, 3) != 0);
                2:       nib_if.ready <= ($urandom_range(0, 3) == 0);
                default: nib_if.ready <= toggle;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check strobes first, then predict for the new request
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        nib_t     want;
        lcd_req_t got_req;
        if (rst_n)
        begin
            if (nib_if.valid && nib_if.ready)
            begin
                if (strobe_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected strobe, expected none actual rs=%0d nibble=%0h",
                             $time, nib_if.reg_select, nib_if.nibble);
                end
                else
                begin
                    want = strobe_q.pop_front();
                    check_field("reg_select", int'(want.reg_select),
                                int'(nib_if.reg_select));
                    check_field("nibble", int'(want.nibble), int'(nib_if.nibble));
                    check_field("pause_before_ms", int'(want.pause_before_ms),
                                int'(nib_if.pause_before_ms));
                    check_field("pause_after_ms", int'(want.pause_after_ms),
                                int'(nib_if.pause_after_ms));
                    check_field("last", int'(want.last), int'(nib_if.last));
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                got_req.op     = req_if.op;
                got_req.value  = req_if.value;
                got_req.column = req_if.column;
                got_req.row    = req_if.row;
                predict_strobes(got_req);
                reqs_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (nib_if.valid && nib_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic add_req(logic [2:0] op, logic [7:0] value, logic [5:0] column,
                           logic [1:0] row);
        lcd_req_t r;
        r.op     = op;
        r.value  = value;
        r.column = column;
        r.row    = row;
        req_backlog.push_back(r);
        reqs_queued++;
    endtask

    function automatic lcd_req_t random_req();
        lcd_req_t r;
        r.op     = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        r.value  = 8'($urandom_range(0, 255));
        r.column = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 40));
        r.row    = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                               : 2'($urandom_range(1, 2));
        if (r.op == OP_PUT_CHAR && $urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       r.value = CHAR_BELL;
                1:       r.value = CHAR_FORM_FEED;
                2:       r.value = CHAR_NEWLINE;
                default: r.value = CHAR_BACKSPACE;
            endcase
        end
        return r;
    endfunction

    // Wait until every request is taken and every strobe is back, then idle
    // a few cycles so nothing is in flight.
    task automatic settle();
        while (reqs_accepted != reqs_queued || req_if.valid)
            @(posedge clk);
        while (strobe_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(cfg_index_t idx, logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LINE_TWO_BASE:   lcd_cfg.line_two_base       = data[6:0];
            CFG_FUNCTION_SET:    lcd_cfg.function_set_cmd    = data;
            CFG_DISPLAY_CONTROL: lcd_cfg.display_control_cmd = data;
            default:             lcd_cfg.entry_mode_cmd      = data;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_all(logic [7:0] base, logic [7:0] fset, logic [7:0] dctl,
                               logic [7:0] emode);
        program_reg(CFG_LINE_TWO_BASE, base);
        program_reg(CFG_FUNCTION_SET, fset);
        program_reg(CFG_DISPLAY_CONTROL, dctl);
        program_reg(CFG_ENTRY_MODE, emode);
    endtask

    task automatic add_random(int count);
        lcd_req_t r;
        repeat (count)
        begin
            r = random_req();
            add_req(r.op, r.value, r.column, r.row);
        end
    endtask

    initial
    begin
        cfg_we    = 1'b0;
        cfg_index = CFG_LINE_TWO_BASE;
        cfg_data  = 8'd0;

        lcd_cfg.line_two_base       = RST_LINE_TWO_BASE;
        lcd_cfg.function_set_cmd    = RST_FUNCTION_SET;
        lcd_cfg.display_control_cmd = RST_DISPLAY_CONTROL;
        lcd_cfg.entry_mode_cmd      = RST_ENTRY_MODE;

        // directed: every op, the control characters, field extremes
        add_req(OP_INIT, 8'h00, 6'd1, 2'd1);
        add_req(OP_PUT_CHAR, CHAR_BELL, 6'd0, 2'd0);
        add_req(OP_PUT_CHAR, CHAR_FORM_FEED, 6'd0, 2'd0);
        add_req(OP_PUT_CHAR, CHAR_NEWLINE, 6'd0, 2'd0);
        add_req(OP_PUT_CHAR, CHAR_BACKSPACE, 6'd0, 2'd0);
        add_req(OP_PUT_CHAR, 8'h00, 6'd63, 2'd3);
        add_req(OP_PUT_CHAR, 8'hFF, 6'd0, 2'd0);
        add_req(OP_PUT_CHAR, 8'h41, 6'd1, 2'd1);
        add_req(OP_GOTO, 8'h00, 6'd1, 2'd1);
        add_req(OP_GOTO, 8'hFF, 6'd40, 2'd2);
        add_req(OP_GOTO, 8'h00, 6'd63, 2'd2);
        add_req(OP_GOTO, 8'h00, 6'd0, 2'd0);
        add_req(OP_GOTO, 8'h00, 6'd63, 2'd3);
        add_req(OP_GOTO, 8'h00, 6'd0, 2'd2);
        add_req(OP_CLEAR_HOME, 8'hFF, 6'd63, 2'd3);
        add_req(OP_SET_DDRAM, 8'hFF, 6'd0, 2'd0);
        add_req(OP_SET_DDRAM, 8'h00, 6'd0, 2'd0);
        add_req(OP_SET_CGRAM, 8'hFF, 6'd0, 2'd0);
        add_req(OP_SET_CGRAM, 8'h00, 6'd0, 2'd0);
        add_req(OP_DATA, 8'h00, 6'd0, 2'd0);
        add_req(OP_DATA, 8'hFF, 6'd63, 2'd3);
        add_req(OP_UNUSED, 8'hFF, 6'd63, 2'd3);
        add_req(OP_DATA, 8'h5A, 6'd0, 2'd0);
        settle();

        program_all(8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        add_req(OP_INIT, 8'h00, 6'd0, 2'd0);
        add_random(63);
        settle();

        program_all(8'd127, 8'hFF, 8'hFF, 8'hFF);
        add_req(OP_INIT, 8'h00, 6'd0, 2'd0);
        add_req(OP_GOTO, 8'h00, 6'd63, 2'd2);
        add_random(63);
        settle();

        program_all(8'd0, 8'h00, 8'h00, 8'h00);
        add_req(OP_INIT, 8'h00, 6'd0, 2'd0);
        add_req(OP_GOTO, 8'h00, 6'd0, 2'd2);
        add_random(63);
        settle();

        program_all(8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        add_req(OP_INIT, 8'h00, 6'd0, 2'd0);
        add_random(63);
        settle();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/clns_pkg.sv
rtl/clns_if.sv
rtl/clns_decode.sv
rtl/clns_nibble_gen.sv
rtl/char_lcd_nibble_sequencer.sv
verif/tb_char_lcd_nibble_sequencer.sv
